// ----- src/tkm_pkg.sv -----
`timescale 1ns / 1ps

package tkm_pkg;

   // store geometry
   localparam int MAX_ENTRIES = 16;
   localparam int MIN_ENTRIES = 3;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // word field widths
   localparam int VALUE_W = 32;
   localparam int TAG_W   = 32;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 5;
   localparam int CFG_W   = 5;
   localparam int ENTRY_W = VALUE_W + TAG_W;

   localparam logic [TAG_W-1:0] NO_TAG = '1;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // effective capacity: raised to the minimum, saturated at the maximum
   function automatic logic [CNT_W-1:0] capacity_of(input logic [CFG_W-1:0] cfg);
      logic [CNT_W-1:0] cap;
      if (int'(cfg) < MIN_ENTRIES) begin
         cap = CNT_W'(MIN_ENTRIES);
      end else if (int'(cfg) > MAX_ENTRIES) begin
         cap = CNT_W'(MAX_ENTRIES);
      end else begin
         cap = CNT_W'(cfg);
      end
      return cap;
   endfunction

endpackage

// ----- src/tkm_ram.sv -----
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module tkm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- src/top_k_minimum_tracker.sv -----
`timescale 1ns / 1ps

// Clear and out-of-range read answer straight from idle; a read goes through ST_RDOUT.
// A full-store add checks the largest entry first (may reject there), then walks one entry per cycle.
// One word at a time, busy high until the result strobe.
// A result shows for exactly one cycle on rsp_valid; the receiver cannot stall it.
// Synchronous active-high reset empties the store and sets capacity to 16; entry RAM is not cleared.
module top_k_minimum_tracker (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_kind,
   input  logic signed [tkm_pkg::VALUE_W-1:0]  req_value,
   input  logic [tkm_pkg::TAG_W-1:0]           req_tag,
   input  logic [tkm_pkg::RANK_W-1:0]          req_rank,
   // response
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output logic [tkm_pkg::COUNT_W-1:0]         rsp_held_count,
   output logic                                rsp_read_valid,
   output logic signed [tkm_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [tkm_pkg::TAG_W-1:0]           rsp_read_tag,
   // config
   input  logic                                csr_we,
   input  logic [tkm_pkg::CFG_W-1:0]           csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHKTOP,
      ST_WALK,
      ST_FILL,
      ST_RDOUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [tkm_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [tkm_pkg::CNT_W-1:0]          held_ff, held_in;
   logic [tkm_pkg::CFG_W-1:0]          cfg_ff, cfg_in;
   logic                               full_ff, full_in;
   logic signed [tkm_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [tkm_pkg::TAG_W-1:0]          tag_ff, tag_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_acc_ff, rsp_acc_in;
   logic [tkm_pkg::COUNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                               rsp_rdv_ff, rsp_rdv_in;
   logic signed [tkm_pkg::VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   logic [tkm_pkg::TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;

   logic                               ram_we;
   logic [tkm_pkg::IDX_W-1:0]          ram_waddr;
   logic [tkm_pkg::ENTRY_W-1:0]        ram_wdata;
   logic [tkm_pkg::IDX_W-1:0]          ram_raddr;
   logic [tkm_pkg::ENTRY_W-1:0]        ram_rdata;
   logic signed [tkm_pkg::VALUE_W-1:0] rd_val;
   logic [tkm_pkg::TAG_W-1:0]          rd_tag;
   logic [tkm_pkg::CNT_W-1:0]          cap;
   logic [tkm_pkg::CNT_W-1:0]          cap_new;
   logic                               move_up;

   // entry store: value in the upper half, tag in the lower
   tkm_ram #(
      .WIDTH(tkm_pkg::ENTRY_W),
      .DEPTH(tkm_pkg::MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_val = ram_rdata[tkm_pkg::ENTRY_W-1:tkm_pkg::TAG_W];
   assign rd_tag = ram_rdata[tkm_pkg::TAG_W-1:0];
   assign cap    = tkm_pkg::capacity_of(cfg_ff);

   // read data always belongs to entry idx_ff-1
   assign ram_raddr = idx_in[tkm_pkg::IDX_W-1:0] - tkm_pkg::IDX_W'(1);

   // shift-up test against the entry below the current slot
   assign move_up = (idx_ff != '0) &&
                    (full_ff ? (rd_val > val_ff) : (rd_val >= val_ff));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      cfg_in       = cfg_ff;
      full_in      = full_ff;
      val_in       = val_ff;
      tag_in       = tag_ff;
      rsp_valid_in = 1'b0;
      rsp_acc_in   = 1'b0;
      rsp_cnt_in   = tkm_pkg::COUNT_W'(held_ff);
      rsp_rdv_in   = 1'b0;
      rsp_val_in   = '0;
      rsp_tag_in   = tkm_pkg::NO_TAG;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[tkm_pkg::IDX_W-1:0];
      ram_wdata    = {val_ff, tag_ff};
      cap_new      = tkm_pkg::capacity_of(csr_wdata);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in = req_value;
               tag_in = req_tag;
               case (tkm_pkg::kind_type'(req_kind))
                  tkm_pkg::KIND_ADD: begin
                     full_in  = (held_ff >= cap);
                     idx_in   = held_ff;
                     state_in = (held_ff >= cap) ? ST_CHKTOP : ST_WALK;
                  end
                  tkm_pkg::KIND_FILL: begin
                     idx_in   = '0;
                     state_in = ST_FILL;
                  end
                  tkm_pkg::KIND_CLEAR: begin
                     held_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_cnt_in   = '0;
                  end
                  tkm_pkg::KIND_READ: begin
                     if (32'(req_rank) < 32'(held_ff)) begin
                        idx_in   = tkm_pkg::CNT_W'(req_rank) + tkm_pkg::CNT_W'(1);
                        state_in = ST_RDOUT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // full store: compare against the largest entry
         ST_CHKTOP: begin
            if (val_ff >= rd_val) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff - tkm_pkg::CNT_W'(1);
               state_in = ST_WALK;
            end
         end

         // walk down, moving larger entries (and, when not full, equal ones) up one slot
         ST_WALK: begin
            ram_we = 1'b1;
            if (move_up) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - tkm_pkg::CNT_W'(1);
            end else begin
               if (!full_ff) begin
                  held_in    = held_ff + tkm_pkg::CNT_W'(1);
                  rsp_cnt_in = tkm_pkg::COUNT_W'(held_ff + tkm_pkg::CNT_W'(1));
               end
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_FILL: begin
            ram_we = 1'b1;
            idx_in = idx_ff + tkm_pkg::CNT_W'(1);
            if (idx_ff == cap - tkm_pkg::CNT_W'(1)) begin
               held_in      = cap;
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b1;
               rsp_cnt_in   = tkm_pkg::COUNT_W'(cap);
               state_in     = ST_IDLE;
            end
         end

         ST_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_rdv_in   = 1'b1;
            rsp_val_in   = rd_val;
            rsp_tag_in   = rd_tag;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write only while idle is up to the user, not enforced; trims the largest entries
      if (csr_we) begin
         cfg_in = csr_wdata;
         if (held_ff > cap_new) begin
            held_in = cap_new;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         cfg_ff       <= tkm_pkg::CFG_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      full_ff    <= full_in;
      val_ff     <= val_in;
      tag_ff     <= tag_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_rdv_ff <= rsp_rdv_in;
      rsp_val_ff <= rsp_val_in;
      rsp_tag_ff <= rsp_tag_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_held_count = rsp_cnt_ff;
   assign rsp_read_valid = rsp_rdv_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rsp_read_tag   = rsp_tag_ff;

endmodule
